// ----- design/gba_pkg.sv -----
package gba_pkg;

  // Fixed widths of the port fields.
  localparam int unsigned CFG_W    = 4;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned INDEX_W  = 13;
  localparam int unsigned GROUP_W  = 3;
  localparam int unsigned LEFT_W   = 11;

  localparam logic [CFG_W-1:0] GROUPS_IN_USE_RESET = 4'd8;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK           = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_FREE      = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_ALREADY_FREE = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_BAD_INDEX    = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PICK,
    ST_SCAN,
    ST_FREE_RD,
    ST_FREE_CHK
  } gba_state_e;

endpackage

// ----- design/gba_bitmap_store.sv -----
module gba_bitmap_store #(
  parameter int WORDS     = 128,
  parameter int WORD_BITS = 64,
  parameter int ADDR_W    = 7,
  parameter int BIT_W     = 6
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  output logic                 ready_o,
  input  logic                 rd_en_i,
  input  logic [ADDR_W-1:0]    rd_addr_i,
  output logic [WORD_BITS-1:0] rd_data_o,
  output logic                 full_o,
  output logic [BIT_W-1:0]     free_bit_o,
  input  logic                 wr_en_i,
  input  logic [ADDR_W-1:0]    wr_addr_i,
  input  logic [WORD_BITS-1:0] wr_data_i
);

  logic [WORD_BITS-1:0] mem [WORDS];
  logic [WORD_BITS-1:0] rd_data_q;
  logic [ADDR_W-1:0]    clr_addr_q;
  logic                 ready_q;

  logic                 mem_we;
  logic [ADDR_W-1:0]    mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;

  // After reset every word is written to zero once, one word a cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
      ready_q    <= 1'b0;
    end else if (!ready_q) begin
      clr_addr_q <= clr_addr_q + ADDR_W'(1);
      if (clr_addr_q == ADDR_W'(WORDS - 1)) begin
        ready_q <= 1'b1;
      end
    end
  end

  assign mem_we    = !ready_q || wr_en_i;
  assign mem_waddr = ready_q ? wr_addr_i : clr_addr_q;
  assign mem_wdata = ready_q ? wr_data_i : '0;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  // Lowest clear bit of the word just read.
  always_comb begin
    free_bit_o = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (!rd_data_q[b]) begin
        free_bit_o = BIT_W'(b);
      end
    end
  end

  assign full_o    = &rd_data_q;
  assign rd_data_o = rd_data_q;
  assign ready_o   = ready_q;

endmodule

// ----- design/group_bitmap_allocator_unit.sv -----
// Channel   | Direction | Transfer happens when     | Carries
// ----------+-----------+---------------------------+------------------------------------------
// request   | in        | start && !busy            | op, use_preferred, preferred_group,
//           |           |                           | free_index
// result    | out       | done_o (one cycle)        | status, unit_index, unit_group,
//           |           |                           | group_free_left
// config    | in        | cfg_we_i                  | groups_in_use
//
// A free reads the bitmap word in ST_FREE_RD and checks and clears the bit in ST_FREE_CHK; a bad
// index is reported from ST_FREE_RD. An allocation checks the count of each group considered in
// ST_PICK, with one more check if all fail, and per searched group reads bitmap words one after
// another in ST_SCAN (at most UNITS_PER_GROUP / WORD_BITS, both powers of two), as the bitmap
// memory has one read port. After reset busy stays high while the bitmap memory is cleared.
// One request is in flight at a time; results cannot be stalled.
module group_bitmap_allocator_unit #(
  parameter int GROUPS          = 8,
  parameter int UNITS_PER_GROUP = 1024,
  parameter int WORD_BITS       = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [gba_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                          start,
  output logic                          busy,
  input  logic                          op_i,
  input  logic                          use_preferred_i,
  input  logic [gba_pkg::GROUP_W-1:0]   preferred_group_i,
  input  logic [gba_pkg::INDEX_W-1:0]   free_index_i,
  output logic                          done_o,
  output logic [gba_pkg::STATUS_W-1:0]  status_o,
  output logic [gba_pkg::INDEX_W-1:0]   unit_index_o,
  output logic [gba_pkg::GROUP_W-1:0]   unit_group_o,
  output logic [gba_pkg::LEFT_W-1:0]    group_free_left_o
);

  import gba_pkg::*;

  localparam int WPG    = UNITS_PER_GROUP / WORD_BITS;
  localparam int TOTAL  = GROUPS * WPG;
  localparam int AW     = (TOTAL > 1) ? $clog2(TOTAL) : 1;
  localparam int GIW    = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int WIW    = (WPG > 1) ? $clog2(WPG) : 1;
  localparam int WPG_LG = $clog2(WPG);
  localparam int UPG_LG = $clog2(UNITS_PER_GROUP);
  localparam int WB_LG  = $clog2(WORD_BITS);
  localparam int NW     = ($clog2(GROUPS + 1) > 4) ? $clog2(GROUPS + 1) : 4;
  localparam int CW     = $clog2(UNITS_PER_GROUP + 1);

  gba_state_e state_q, state_d;

  logic [CFG_W-1:0]   groups_in_use_q;
  logic [CW-1:0]      cnt_q [GROUPS];
  logic               have_pref_q, have_pref_d;
  logic               first_q, first_d;
  logic [GIW-1:0]     pref_q, pref_d;
  logic [NW-1:0]      seq_q, seq_d;
  logic [GIW-1:0]     grp_q, grp_d;
  logic [WIW:0]       iss_w_q, iss_w_d;
  logic               pend_q, pend_d;
  logic [WIW-1:0]     pend_w_q, pend_w_d;
  logic [INDEX_W-1:0] findex_q, findex_d;

  logic                done_q, done_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic [INDEX_W-1:0]  unit_q, unit_d;
  logic [GROUP_W-1:0]  group_q, group_d;
  logic [LEFT_W-1:0]   left_q, left_d;

  logic              cnt_we;
  logic [GIW-1:0]    cnt_wg;
  logic [CW-1:0]     cnt_wdata;
  logic [GIW-1:0]    cnt_rd_g;
  logic [CW-1:0]     cnt_rd;

  logic                 mem_ready;
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic [WORD_BITS-1:0] rd_data;
  logic                 rd_full;
  logic [WB_LG-1:0]     free_bit;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [WORD_BITS-1:0] wr_data;

  logic [NW-1:0]        cfg_ext;
  logic [NW-1:0]        n_groups;
  logic [NW-1:0]        pref_in;
  logic                 accept;
  logic [GIW-1:0]       cand_g;
  logic [31:0]          unit_calc;
  logic [AW-1:0]        free_addr;
  logic [GIW-1:0]       free_g;
  logic [WB_LG-1:0]     free_pos;
  logic [WORD_BITS-1:0] free_mask;
  logic                 free_bad;

  gba_bitmap_store #(
    .WORDS     (TOTAL),
    .WORD_BITS (WORD_BITS),
    .ADDR_W    (AW),
    .BIT_W     (WB_LG)
  ) u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ready_o    (mem_ready),
    .rd_en_i    (rd_en),
    .rd_addr_i  (rd_addr),
    .rd_data_o  (rd_data),
    .full_o     (rd_full),
    .free_bit_o (free_bit),
    .wr_en_i    (wr_en),
    .wr_addr_i  (wr_addr),
    .wr_data_i  (wr_data)
  );

  assign cfg_ext  = NW'(groups_in_use_q);
  assign n_groups = (cfg_ext > NW'(GROUPS)) ? NW'(GROUPS) : cfg_ext;
  assign pref_in  = NW'(preferred_group_i);
  assign busy     = (state_q != ST_IDLE) || !mem_ready;
  assign accept   = start && !busy;

  // The preferred group goes first, then groups 0 upward.
  assign cand_g = first_q ? pref_q : GIW'(seq_q);

  assign unit_calc = (32'(grp_q) << UPG_LG) | (32'(pend_w_q) << WB_LG) | 32'(free_bit);

  assign free_addr = AW'(32'(findex_q) >> WB_LG);
  assign free_g    = GIW'(32'(findex_q) >> UPG_LG);
  assign free_pos  = findex_q[WB_LG-1:0];
  assign free_mask = WORD_BITS'(1) << free_pos;
  assign free_bad  = (findex_q == '0) ||
                     (32'(findex_q) >= (32'(n_groups) << UPG_LG));

  always_comb begin
    unique case (state_q)
      ST_PICK:     cnt_rd_g = cand_g;
      ST_FREE_CHK: cnt_rd_g = free_g;
      default:     cnt_rd_g = grp_q;
    endcase
  end
  assign cnt_rd = cnt_q[cnt_rd_g];

  always_comb begin
    state_d     = state_q;
    have_pref_d = have_pref_q;
    first_d     = first_q;
    pref_d      = pref_q;
    seq_d       = seq_q;
    grp_d       = grp_q;
    iss_w_d     = iss_w_q;
    pend_d      = pend_q;
    pend_w_d    = pend_w_q;
    findex_d    = findex_q;
    done_d      = 1'b0;
    status_d    = status_q;
    unit_d      = unit_q;
    group_d     = group_q;
    left_d      = left_q;
    cnt_we      = 1'b0;
    cnt_wg      = cnt_rd_g;
    cnt_wdata   = cnt_rd;
    rd_en       = 1'b0;
    rd_addr     = free_addr;
    wr_en       = 1'b0;
    wr_addr     = free_addr;
    wr_data     = rd_data & ~free_mask;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          have_pref_d = use_preferred_i && (pref_in < n_groups);
          first_d     = use_preferred_i && (pref_in < n_groups);
          pref_d      = GIW'(pref_in);
          seq_d       = '0;
          findex_d    = free_index_i;
          state_d     = (op_i == OP_FREE) ? ST_FREE_RD : ST_PICK;
        end
      end

      ST_PICK: begin
        if (!first_q && (seq_q >= n_groups)) begin
          done_d   = 1'b1;
          status_d = STATUS_NO_FREE;
          unit_d   = '0;
          group_d  = '0;
          left_d   = '0;
          state_d  = ST_IDLE;
        end else begin
          if (first_q) begin
            first_d = 1'b0;
          end else begin
            seq_d = seq_q + NW'(1);
          end
          // The preferred group is not tried twice, and an empty group not at all.
          if (!(!first_q && have_pref_q && (seq_q == NW'(pref_q))) && (cnt_rd != '0)) begin
            grp_d   = cand_g;
            iss_w_d = '0;
            pend_d  = 1'b0;
            state_d = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        // Words are read back to back; the first one with a clear bit ends the scan of the group.
        rd_en    = (32'(iss_w_q) < WPG);
        rd_addr  = AW'((32'(grp_q) << WPG_LG) + 32'(iss_w_q));
        pend_d   = rd_en;
        pend_w_d = WIW'(iss_w_q);
        if (rd_en) begin
          iss_w_d = iss_w_q + (WIW + 1)'(1);
        end
        if (pend_q) begin
          if (!rd_full) begin
            wr_en     = 1'b1;
            wr_addr   = AW'((32'(grp_q) << WPG_LG) + 32'(pend_w_q));
            wr_data   = rd_data | (WORD_BITS'(1) << free_bit);
            cnt_we    = 1'b1;
            cnt_wg    = grp_q;
            cnt_wdata = cnt_rd - CW'(1);
            if (unit_calc != 32'd0) begin
              done_d   = 1'b1;
              status_d = STATUS_OK;
              unit_d   = INDEX_W'(unit_calc);
              group_d  = GROUP_W'(grp_q);
              left_d   = LEFT_W'(cnt_rd - CW'(1));
              state_d  = ST_IDLE;
            end else begin
              // Unit zero is consumed but never handed out.
              state_d = ST_PICK;
            end
          end else if (32'(pend_w_q) == WPG - 1) begin
            state_d = ST_PICK;
          end
        end
      end

      ST_FREE_RD: begin
        if (free_bad) begin
          done_d   = 1'b1;
          status_d = STATUS_BAD_INDEX;
          unit_d   = '0;
          group_d  = '0;
          left_d   = '0;
          state_d  = ST_IDLE;
        end else begin
          rd_en   = 1'b1;
          state_d = ST_FREE_CHK;
        end
      end

      ST_FREE_CHK: begin
        done_d  = 1'b1;
        state_d = ST_IDLE;
        if ((rd_data & free_mask) == '0) begin
          status_d = STATUS_ALREADY_FREE;
          unit_d   = '0;
          group_d  = '0;
          left_d   = '0;
        end else begin
          wr_en     = 1'b1;
          cnt_we    = 1'b1;
          cnt_wg    = free_g;
          cnt_wdata = cnt_rd + CW'(1);
          status_d  = STATUS_OK;
          unit_d    = findex_q;
          group_d   = GROUP_W'(free_g);
          left_d    = LEFT_W'(cnt_rd + CW'(1));
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      groups_in_use_q <= GROUPS_IN_USE_RESET;
      done_q          <= 1'b0;
      have_pref_q     <= 1'b0;
      first_q         <= 1'b0;
      seq_q           <= '0;
      iss_w_q         <= '0;
      pend_q          <= 1'b0;
      for (int g = 0; g < GROUPS; g++) begin
        cnt_q[g] <= CW'(UNITS_PER_GROUP);
      end
    end else begin
      if (cfg_we_i) begin
        groups_in_use_q <= cfg_wdata_i;
      end
      done_q      <= done_d;
      have_pref_q <= have_pref_d;
      first_q     <= first_d;
      seq_q       <= seq_d;
      iss_w_q     <= iss_w_d;
      pend_q      <= pend_d;
      if (cnt_we) begin
        cnt_q[cnt_wg] <= cnt_wdata;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pref_q   <= pref_d;
    grp_q    <= grp_d;
    pend_w_q <= pend_w_d;
    findex_q <= findex_d;
    status_q <= status_d;
    unit_q   <= unit_d;
    group_q  <= group_d;
    left_q   <= left_d;
  end

  assign done_o            = done_q;
  assign status_o          = status_q;
  assign unit_index_o      = unit_q;
  assign unit_group_o      = group_q;
  assign group_free_left_o = left_q;

endmodule
